// ===== rtl/kvdt_pkg.sv =====
// kvdt_pkg: shared types, codes and defaults for the key/value dictionary table
`timescale 1ns / 1ps
`default_nettype none
package kvdt_pkg;

    // default table depth
    localparam int DEFAULT_CAPACITY = 16;

    localparam int KEY_W    = 32;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;

    // input transaction payload
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic signed [KEY_W-1:0] lookup_key;
        logic signed [VAL_W-1:0] new_value;
    } t_in;

    // output transaction payload
    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic signed [VAL_W-1:0] found_value;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic clear_en;
        logic start;
        logic scan_en;
        logic exec;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clear_done;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/key_value_dictionary_table_top.sv =====
// key_value_dictionary_table_top: dictionary table with insert, search and delete
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------------
//   input   | in        | i_valid / o_ready  | i_data: operation, lookup_key, new_value
//   output  | out       | o_valid / i_ready  | o_data: status, found_value
//
// Each operation is accepted, then every entry is streamed out of the single
// read port of the entry memory and compared, and then the result is written
// back and loaded into the output register.
// After reset a clearing pass marks all entries free; o_ready stays low
// meanwhile. The next operation is accepted while a result still waits in
// the output register; a stall holds only the execute step.
`timescale 1ns / 1ps
`default_nettype none
module key_value_dictionary_table_top #(
    parameter int CAPACITY = kvdt_pkg::DEFAULT_CAPACITY
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire kvdt_pkg::t_in i_data,
    output logic             o_valid,
    input  wire logic        i_ready,
    output kvdt_pkg::t_out   o_data
);
    import kvdt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing
    kvdt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // storage and compare
    kvdt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
`default_nettype wire

// ===== rtl/kvdt_ctrl.sv =====
// kvdt_ctrl: sequencing state machine for clear, scan and execute phases
`timescale 1ns / 1ps
`default_nettype none
module kvdt_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire kvdt_pkg::t_sts i_sts,
    output kvdt_pkg::t_cmd     o_cmd
);
    import kvdt_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_EXEC  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (i_sts.clear_done) n_state = S_IDLE;
            S_IDLE:  if (i_valid)          n_state = S_SCAN;
            S_SCAN:  if (i_sts.scan_done)  n_state = S_EXEC;
            S_EXEC:  if (i_sts.out_free)   n_state = S_IDLE;
            default:                       n_state = S_CLEAR;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // commands to the datapath
    always_comb begin
        o_ready        = (r_state == S_IDLE);
        o_cmd.clear_en = (r_state == S_CLEAR);
        o_cmd.start    = (r_state == S_IDLE) && i_valid;
        o_cmd.scan_en  = (r_state == S_SCAN);
        o_cmd.exec     = (r_state == S_EXEC) && i_sts.out_free;
    end

endmodule
`default_nettype wire

// ===== rtl/kvdt_dpath.sv =====
// kvdt_dpath: entry memory, key scan, update logic and output register
`timescale 1ns / 1ps
`default_nettype none
module kvdt_dpath #(
    parameter int CAPACITY = kvdt_pkg::DEFAULT_CAPACITY
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire kvdt_pkg::t_cmd i_cmd,
    output kvdt_pkg::t_sts     o_sts,
    input  wire kvdt_pkg::t_in i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output kvdt_pkg::t_out     o_data
);
    import kvdt_pkg::*;

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int WORD_W = 1 + KEY_W + VAL_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // memory word: {valid, key, value}
    logic [WORD_W-1:0] r_mem [CAPACITY];
    logic [WORD_W-1:0] r_rdata;

    // captured operation
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    // scan control
    logic [IDX_W-1:0] r_clr_idx;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_issued_all;
    logic             r_cmp_vld;
    logic [IDX_W-1:0] r_cmp_idx;

    // scan results
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [VAL_W-1:0] r_hit_value;
    logic             r_free;
    logic [IDX_W-1:0] r_free_idx;

    // output register
    logic r_out_valid;
    t_out r_out;

    // execute-phase decisions
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_word;
    logic [STATUS_W-1:0] ex_status;
    logic [VAL_W-1:0] ex_value;

    logic             rd_valid_bit;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_value;

    assign rd_valid_bit = r_rdata[WORD_W-1];
    assign rd_key       = r_rdata[KEY_W+VAL_W-1:VAL_W];
    assign rd_value     = r_rdata[VAL_W-1:0];

    // status to the controller
    always_comb begin
        o_sts.clear_done = (r_clr_idx == LAST_IDX);
        o_sts.scan_done  = r_cmp_vld && (r_cmp_idx == LAST_IDX);
        o_sts.out_free   = !r_out_valid || i_ready;
    end

    // decide result and memory write for the current operation
    always_comb begin
        ex_status = ST_NOT_FOUND;
        ex_value  = '0;
        wr_en     = 1'b0;
        wr_addr   = r_hit_idx;
        wr_word   = {1'b1, r_key, r_val};
        case (r_op)
            OP_INSERT: begin
                if (r_hit) begin
                    ex_status = ST_UPDATED;
                    wr_en     = i_cmd.exec;
                end else if (r_free) begin
                    ex_status = ST_INSERTED;
                    wr_en     = i_cmd.exec;
                    wr_addr   = r_free_idx;
                end else begin
                    ex_status = ST_FULL;
                end
            end
            OP_SEARCH: begin
                if (r_hit) begin
                    ex_status = ST_FOUND;
                    ex_value  = r_hit_value;
                end
            end
            OP_DELETE: begin
                if (r_hit) begin
                    ex_status = ST_DELETED;
                    wr_en     = i_cmd.exec;
                    wr_word   = {1'b0, r_key, r_val};
                end
            end
            default: begin
                ex_status = ST_NOT_FOUND;
            end
        endcase
        // clearing pass after reset
        if (i_cmd.clear_en) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
            wr_word = {1'b0, r_key, r_val};
        end
    end

    // entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
        r_rdata <= r_mem[r_rd_idx];
    end

    // capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_data.operation;
            r_key <= i_data.lookup_key;
            r_val <= i_data.new_value;
        end
    end

    // clear sweep counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear_en && (r_clr_idx != LAST_IDX)) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    // read address sequencing, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx     <= '0;
            r_issued_all <= 1'b0;
            r_cmp_vld    <= 1'b0;
        end else if (i_cmd.start) begin
            r_rd_idx     <= '0;
            r_issued_all <= 1'b0;
            r_cmp_vld    <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_en && !r_issued_all;
            if (i_cmd.scan_en && !r_issued_all) begin
                r_cmp_idx <= r_rd_idx;
                if (r_rd_idx == LAST_IDX) begin
                    r_issued_all <= 1'b1;
                end else begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
        end
    end

    // compare registered entry against the key, track first free entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (i_cmd.start) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_cmp_vld) begin
            if (rd_valid_bit && (rd_key == r_key)) begin
                r_hit       <= 1'b1;
                r_hit_idx   <= r_cmp_idx;
                r_hit_value <= rd_value;
            end
            if (!rd_valid_bit && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.exec) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out.status      <= ex_status;
            r_out.found_value <= ex_value;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the key/value dictionary table, directed rows then random
`timescale 1ns / 1ps
module testbench;
    import kvdt_pkg::*;

    localparam int CAPACITY = DEFAULT_CAPACITY;
    localparam int RANDOM_OPS = 1150;
    localparam int MAX_CYCLES = 400000;
    localparam int LONG_HOLD_AT = 250;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int DRAIN_PAUSE_AT = 575;
    localparam int POOL_SIZE = 24;

    // code left unassigned by the package, answered as a miss
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    // one row of the directed table
    typedef struct {
        t_in  op_item;
        logic known;
        t_out known_res;
    } dict_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    t_in  i_data = '0;
    logic o_ready;
    logic o_valid;
    t_out o_data;

    // shadow copy of the table
    logic signed [KEY_W-1:0] shadow_key [CAPACITY];
    logic signed [VAL_W-1:0] shadow_val [CAPACITY];
    logic [CAPACITY-1:0]     shadow_used = '0;

    t_out      pending_results [$];
    dict_row_t directed_ops [$];
    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

    int   error_count = 0;
    int   results_seen = 0;
    int   cycle_count = 0;
    logic sender_calm = 1'b0;

    key_value_dictionary_table_top #(
        .CAPACITY(CAPACITY)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always #6 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // apply one operation to the shadow table and return its result
    function automatic t_out dict_apply(input t_in item);
        t_out res;
        int hit;
        int slot;
        res.status = ST_NOT_FOUND;
        res.found_value = '0;
        hit = -1;
        slot = -1;
        // scan downward so the lowest matching and lowest free entries win
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (shadow_used[i] && shadow_key[i] == item.lookup_key) hit = i;
            if (!shadow_used[i]) slot = i;
        end
        case (item.operation)
            OP_INSERT: begin
                if (hit >= 0) begin
                    shadow_val[hit] = item.new_value;
                    res.status = ST_UPDATED;
                end else if (slot >= 0) begin
                    shadow_key[slot] = item.lookup_key;
                    shadow_val[slot] = item.new_value;
                    shadow_used[slot] = 1'b1;
                    res.status = ST_INSERTED;
                end else begin
                    res.status = ST_FULL;
                end
            end
            OP_SEARCH: begin
                if (hit >= 0) begin
                    res.status = ST_FOUND;
                    res.found_value = shadow_val[hit];
                end
            end
            OP_DELETE: begin
                if (hit >= 0) begin
                    shadow_used[hit] = 1'b0;
                    res.status = ST_DELETED;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic add_row(input logic [OP_W-1:0] op, input logic signed [KEY_W-1:0] key,
                           input logic signed [VAL_W-1:0] val, input logic known,
                           input logic [STATUS_W-1:0] st, input logic signed [VAL_W-1:0] fv);
        dict_row_t row;
        row.op_item.operation = op;
        row.op_item.lookup_key = key;
        row.op_item.new_value = val;
        row.known = known;
        row.known_res.status = st;
        row.known_res.found_value = fv;
        directed_ops.push_back(row);
    endtask

    // random operation, mostly on a small key pool so hits and a full table are common
    function automatic t_in random_op(input int insert_pct);
        t_in item;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < insert_pct) item.operation = OP_INSERT;
        else if (pick < insert_pct + (95 - insert_pct) / 2) item.operation = OP_SEARCH;
        else if (pick < 95) item.operation = OP_DELETE;
        else item.operation = OP_UNUSED;
        if ($urandom_range(0, 99) < 85) item.lookup_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else item.lookup_key = $urandom;
        item.new_value = $urandom;
        return item;
    endfunction

    // offer one transaction and record its expected result once accepted
    task automatic send_op(input t_in item, input logic known, input t_out known_res);
        int gap;
        t_out predicted;
        gap = sender_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= item;
        do @(posedge i_clk); while (!o_ready);
        predicted = dict_apply(item);
        pending_results.push_back(known ? known_res : predicted);
    endtask

    // receiving side: random stalls, one long hold, and result checking
    initial begin : result_side
        int stall;
        logic receiver_calm;
        t_out want;
        t_out got;
        receiver_calm = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (results_seen % 40 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
            if (results_seen == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
            else stall = receiver_calm ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            got = o_data;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: status %0d, found_value %0d",
                       got.status, got.found_value);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
                    error_count++;
                end
                if (got.found_value !== want.found_value) begin
                    $error("found_value mismatch: expected %0d, actual %0d",
                           want.found_value, got.found_value);
                    error_count++;
                end
            end
            results_seen++;
        end
    end

    // stimulus
    initial begin : op_side
        int insert_pct;
        t_in item;
        t_out none;
        none = '0;

        // key pool: extremes, random keys, and near misses one bit away
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        for (int i = 4; i < 16; i++) key_pool[i] = $urandom;
        for (int i = 16; i < POOL_SIZE; i++)
            key_pool[i] = key_pool[i - 12] ^ (32'h1 << $urandom_range(0, 31));

        // directed table: empty table misses
        add_row(OP_SEARCH, '0, '0, 1'b1, ST_NOT_FOUND, '0);
        add_row(OP_DELETE, '0, '1, 1'b1, ST_NOT_FOUND, '0);
        // extremes of key and value
        add_row(OP_INSERT, KEY_MIN, KEY_MAX, 1'b1, ST_INSERTED, '0);
        add_row(OP_INSERT, KEY_MAX, KEY_MIN, 1'b1, ST_INSERTED, '0);
        add_row(OP_INSERT, -1, -1, 1'b1, ST_INSERTED, '0);
        add_row(OP_INSERT, '0, '0, 1'b1, ST_INSERTED, '0);
        add_row(OP_SEARCH, -1, '0, 1'b1, ST_FOUND, -1);
        // update of an existing key, then delete
        add_row(OP_INSERT, KEY_MIN, 32'h5A5A_A5A5, 1'b1, ST_UPDATED, '0);
        add_row(OP_SEARCH, KEY_MIN, '0, 1'b0, ST_NOT_FOUND, '0);
        add_row(OP_DELETE, -1, '0, 1'b1, ST_DELETED, '0);
        // unused code on a key that is present
        add_row(OP_UNUSED, KEY_MAX, -1, 1'b1, ST_NOT_FOUND, '0);
        // fill the rest of the table, the freed entry first
        for (int k = 0; k < CAPACITY - 3; k++)
            add_row(OP_INSERT, 32'h0F0F_1000 + k, 32'hC3C3_0000 ^ k, 1'b0, ST_NOT_FOUND, '0);
        // full table, then free one entry and take it again
        add_row(OP_INSERT, 32'h1234_5678, 32'h1, 1'b1, ST_FULL, '0);
        add_row(OP_SEARCH, 32'h1234_5678, '0, 1'b1, ST_NOT_FOUND, '0);
        add_row(OP_DELETE, '0, '0, 1'b1, ST_DELETED, '0);
        add_row(OP_INSERT, 32'h1234_5678, 32'h7, 1'b1, ST_INSERTED, '0);
        add_row(OP_SEARCH, 32'h1234_5678, '0, 1'b0, ST_NOT_FOUND, '0);

        // reset
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_ops[r])
            send_op(directed_ops[r].op_item, directed_ops[r].known, directed_ops[r].known_res);

        // random segments, each leaning toward filling or emptying the table
        insert_pct = 45;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 40 == 0) begin
                sender_calm = ($urandom_range(0, 2) == 0);
                case ($urandom_range(0, 2))
                    0: insert_pct = 25;
                    1: insert_pct = 45;
                    default: insert_pct = 65;
                endcase
            end
            if (n == DRAIN_PAUSE_AT) begin
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_results.size() != 0);
            end
            item = random_op(insert_pct);
            send_op(item, 1'b0, none);
        end

        // drain
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
        repeat (3 * CAPACITY + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
